[rtl/hdmf_pkg.sv]
// ----------------------------------------------------------------------------
// hdmf_pkg
// Shared types, constants and hash helper for the duplicate message filter.
// ----------------------------------------------------------------------------
package hdmf_pkg;

  localparam int CACHE_ENTRIES_DEF = 1024;

  localparam int NODE_W  = 32;
  localparam int SEQ_W   = 32;
  localparam int TIME_W  = 64;
  localparam int WIN_W   = 32;
  localparam int ENTRY_W = NODE_W + SEQ_W + TIME_W;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

  // one step per byte, four bytes per word
  localparam int            STEP_W    = 2;
  localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

  // configuration port
  localparam int            CFG_AW          = 2;
  localparam int            CFG_DW          = 32;
  localparam logic [CFG_AW-1:0] CFG_ADDR_WINDOW = 2'd0;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_step;
    logic rd;
    logic cmp;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

  // one FNV-1a byte step; the prime 0x01000193 is applied as shifts and adds
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/hdmf_ctrl.sv]
// ----------------------------------------------------------------------------
// hdmf_ctrl
// Sequencer: clear pass, hash, index reduction, table read and update.
// ----------------------------------------------------------------------------
module hdmf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output hdmf_pkg::cmd_t cmd,
  input  hdmf_pkg::sts_t sts
);
  import hdmf_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/hdmf_dp.sv]
// ----------------------------------------------------------------------------
// hdmf_dp
// Datapath: FNV-1a hashers, modulo reducer, entry table and age compare.
// ----------------------------------------------------------------------------
module hdmf_dp #(
  parameter int CACHE_ENTRIES = hdmf_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hdmf_pkg::cmd_t               cmd,
  output hdmf_pkg::sts_t               sts,
  input  logic [hdmf_pkg::NODE_W-1:0]  in_source_node,
  input  logic [hdmf_pkg::SEQ_W-1:0]   in_sequence_number,
  input  logic [hdmf_pkg::TIME_W-1:0]  in_now_us,
  input  logic [hdmf_pkg::WIN_W-1:0]   window_us,
  output logic                         out_duplicate
);
  import hdmf_pkg::*;

  localparam int          IW   = $clog2(CACHE_ENTRIES);
  localparam logic [IW:0] N_C  = (IW+1)'(CACHE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

  logic [NODE_W-1:0]  node_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [TIME_W-1:0]  now_r;
  logic [NODE_W-1:0]  nsh_r;
  logic [SEQ_W-1:0]   ssh_r;
  logic [31:0]        hn_r, hs_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      clr_cnt_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               dup_r;

  logic [ENTRY_W-1:0] mem [CACHE_ENTRIES];

  logic [31:0]        key;
  logic [NODE_W-1:0]  rd_node;
  logic [SEQ_W-1:0]   rd_seq;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  age;
  logic               dup;
  logic               we;
  logic [IW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  // reduce eight key bits into the index, MSB first
  always_comb begin
    logic [IW:0] t;
    idx_nxt = idx_r;
    key     = hn_r ^ hs_r;
    for (int i = 0; i < 8; i++) begin
      t = {idx_nxt, key[31-i]};
      if (t >= N_C) begin
        t = t - N_C;
      end
      idx_nxt = t[IW-1:0];
    end
  end

  assign rd_node = rd_data_r[NODE_W-1:0];
  assign rd_seq  = rd_data_r[NODE_W+SEQ_W-1:NODE_W];
  assign rd_time = rd_data_r[ENTRY_W-1:NODE_W+SEQ_W];
  assign age     = now_r - rd_time;
  assign dup     = (rd_node == node_r) && (rd_seq == seq_r) &&
                   (age < {{(TIME_W-WIN_W){1'b0}}, window_us});

  assign we    = cmd.clr_wr || (cmd.cmp && !dup);
  assign waddr = cmd.clr_wr ? clr_cnt_r : idx_r;
  assign wdata = cmd.clr_wr ? '0 : {now_r, seq_r, node_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r <= in_source_node;
      seq_r  <= in_sequence_number;
      now_r  <= in_now_us;
      nsh_r  <= in_source_node;
      ssh_r  <= in_sequence_number;
      hn_r   <= FNV_BASIS;
      hs_r   <= FNV_BASIS;
      idx_r  <= '0;
    end else if (cmd.hash_step) begin
      hn_r  <= fnv_step(hn_r, nsh_r[7:0]);
      hs_r  <= fnv_step(hs_r, ssh_r[7:0]);
      nsh_r <= nsh_r >> 8;
      ssh_r <= ssh_r >> 8;
    end else if (cmd.mod_step) begin
      idx_r <= idx_nxt;
      hn_r  <= hn_r << 8;
      hs_r  <= hs_r << 8;
    end
    if (cmd.cmp) begin
      dup_r <= dup;
    end
  end

  assign out_duplicate = dup_r;

endmodule

[rtl/hashed_duplicate_message_filter_core.sv]
// ----------------------------------------------------------------------------
// hashed_duplicate_message_filter_core
// Duplicate message filter on a hashed, direct-mapped table of recent messages.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_source_node, in_sequence_number and in_now_us and raise
//   start; the transaction is taken at the clock edge where start is high and
//   busy is low. busy stays high until the result has been produced.
//   Output: out_valid is high for exactly one cycle with out_duplicate; the
//   transaction completes at the edge that ends that cycle. The receiver
//   cannot stall, so no output buffering beyond that register exists.
//   Sequencing: after the idle cycle where start is taken, the sequencer runs
//   four FNV-1a byte steps, four 8-bit steps of the modulo reducer, one table
//   read and one compare/update step. A new transaction is taken only when
//   busy is low again, so transactions do not overlap.
//   Reset: synchronous, active low. The window register returns to 1000000 us
//   and the table is cleared by a pass over all CACHE_ENTRIES entries, one entry
//   per cycle, with busy high; configuration writes are taken during the pass.
//   Configuration: APB-style port; window_us at byte address 0, pready high.
// ----------------------------------------------------------------------------
module hashed_duplicate_message_filter_core #(
  parameter int CACHE_ENTRIES = hdmf_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [hdmf_pkg::NODE_W-1:0]   in_source_node,
  input  logic [hdmf_pkg::SEQ_W-1:0]    in_sequence_number,
  input  logic [hdmf_pkg::TIME_W-1:0]   in_now_us,
  // result channel
  output logic                          out_valid,
  output logic                          out_duplicate,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdmf_pkg::CFG_AW-1:0]   paddr,
  input  logic [hdmf_pkg::CFG_DW-1:0]   pwdata,
  output logic [hdmf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import hdmf_pkg::*;

  logic [WIN_W-1:0] window_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  // Register write completes in the access phase; other addresses are dropped.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == CFG_ADDR_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_r <= pwdata;
    end
  end

  // Read back the window; unmapped addresses read as zero.
  assign prdata = (paddr == CFG_ADDR_WINDOW) ? window_r : '0;

  // Sequencer: issues at most one command per cycle to the datapath.
  hdmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: hashes, index reduction, table and age compare.
  hdmf_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_source_node     (in_source_node),
    .in_sequence_number (in_sequence_number),
    .in_now_us          (in_now_us),
    .window_us          (window_r),
    .out_duplicate      (out_duplicate)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result only follows a cycle in which the block was working.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // Results are single-cycle strobes; no two come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
